FILE: hdl/encoder_position_pid_unit_defines.svh
// Assertion helpers for the encoder position PID unit.
`ifndef ENCODER_POSITION_PID_UNIT_DEFINES_SVH
`define ENCODER_POSITION_PID_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define EPP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define EPP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/epp_pkg.sv
package epp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int CPR_W         = 24;
   localparam int INTEG_W       = 48;
   localparam int CSR_IDX_W     = 3;
   localparam int DIV_W         = 64;
   localparam int PROD_W        = 65;
   localparam int TERM_W        = 64;

   localparam logic signed [DATA_W-1:0] SETPOINT_RST = 32'sd11796480;
   localparam logic signed [DATA_W-1:0] GAIN_P_RST   = 32'sd327680;
   localparam logic signed [DATA_W-1:0] GAIN_I_RST   = 32'sd6554;
   localparam logic signed [DATA_W-1:0] GAIN_D_RST   = 32'sd3932;
   localparam logic [CPR_W-1:0]         CPR_RST      = 24'd88064;
   localparam logic [DATA_W-1:0]        DEG_PER_REV  = 32'd360;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SETPOINT = 3'd0,
      REG_GAIN_P   = 3'd1,
      REG_GAIN_I   = 3'd2,
      REG_GAIN_D   = 3'd3,
      REG_CPR      = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
      logic [CPR_W-1:0]         cpr;
   } epp_cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MPOS, ST_DPOS_GO, ST_DPOS_WAIT, ST_POS, ST_ERR, ST_MP, ST_PT,
      ST_MINC, ST_INTEG, ST_MIHI, ST_IHI, ST_MILO, ST_ITERM, ST_MD, ST_DD_GO,
      ST_DD_WAIT, ST_DT, ST_FIN
   } epp_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL_POS, OP_DIV_POS, OP_POS, OP_ERR, OP_MUL_P, OP_P_TERM,
      OP_MUL_INC, OP_INTEG, OP_MUL_IHI, OP_HI, OP_MUL_ILO, OP_I_TERM, OP_MUL_D,
      OP_DIV_D, OP_D_TERM, OP_FINISH
   } epp_op_type;

   typedef struct packed {
      epp_op_type op;
      logic       out_load;
   } epp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic zero;
   } epp_status_type;

endpackage

FILE: hdl/epp_ifs.sv
interface epp_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [epp_pkg::DATA_W-1:0] encoder_count;
   logic [epp_pkg::DATA_W-1:0]        time_us;
   modport source (output valid, encoder_count, time_us, input ready);
   modport sink (input valid, encoder_count, time_us, output ready);
endinterface

interface epp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [epp_pkg::DATA_W-1:0] drive;
   logic signed [epp_pkg::DATA_W-1:0] position_deg;
   logic                             drive_saturated;
   logic                             zero_interval;
   modport source (output valid, drive, position_deg, drive_saturated, zero_interval,
                   input ready);
   modport sink (input valid, drive, position_deg, drive_saturated, zero_interval,
                 output ready);
endinterface

interface epp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [epp_pkg::CSR_IDX_W-1:0]       index;
   logic [epp_pkg::DATA_W-1:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/epp_divider.sv
// Restoring divider, two quotient bits per cycle.
module epp_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [epp_pkg::DIV_W-1:0]    dividend,
   input  logic [epp_pkg::DATA_W-1:0]   divisor,
   output logic [epp_pkg::DIV_W-1:0]    quotient,
   output logic                         busy,
   output logic                         done
);
   localparam int STEPS = epp_pkg::DIV_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic                        busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [epp_pkg::DATA_W-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [epp_pkg::DIV_W-1:0]   q_ff, q_in;
   logic [epp_pkg::DATA_W:0]    r_a, r_b;
   logic [epp_pkg::DATA_W-1:0]  rem_a;
   logic                        bit_a, bit_b;

   always_comb begin
      r_a   = {rem_ff, q_ff[epp_pkg::DIV_W-1]};
      bit_a = (r_a >= {1'b0, dvs_ff});
      rem_a = bit_a ? epp_pkg::DATA_W'(r_a - {1'b0, dvs_ff}) : r_a[epp_pkg::DATA_W-1:0];
      r_b   = {rem_a, q_ff[epp_pkg::DIV_W-2]};
      bit_b = (r_b >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         q_in    = dividend;
      end else if (busy_ff) begin
         rem_in = bit_b ? epp_pkg::DATA_W'(r_b - {1'b0, dvs_ff}) : r_b[epp_pkg::DATA_W-1:0];
         q_in   = {q_ff[epp_pkg::DIV_W-3:0], bit_a, bit_b};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;
endmodule

FILE: hdl/epp_datapath.sv
// Shared multiplier, divider and PID state.
module epp_datapath #(
   parameter int FRAC_BITS = epp_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  epp_pkg::epp_cfg_type                cfg,
   input  logic signed [epp_pkg::DATA_W-1:0]   req_count,
   input  logic [epp_pkg::DATA_W-1:0]          req_time,
   input  epp_pkg::epp_cmd_type                cmd,
   output epp_pkg::epp_status_type             status,
   output logic signed [epp_pkg::DATA_W-1:0]   drive,
   output logic signed [epp_pkg::DATA_W-1:0]   position_deg,
   output logic                                drive_saturated,
   output logic                                zero_interval
);
   localparam int DW = epp_pkg::DATA_W;
   localparam int IW = epp_pkg::INTEG_W;
   localparam int TW = epp_pkg::TERM_W;
   localparam int PW = epp_pkg::PROD_W;

   function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
      mag32 = v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   function automatic logic signed [DW-1:0] sat32(input logic signed [TW+1:0] v);
      if (v > (TW+2)'(signed'(33'sh0_7FFF_FFFF)))
         sat32 = 32'sh7FFF_FFFF;
      else if (v < (TW+2)'(signed'(33'sh1_8000_0000)))
         sat32 = 32'sh8000_0000;
      else
         sat32 = DW'(v);
   endfunction

   logic signed [DW-1:0] cnt_ff, cnt_in, pos_ff, pos_in, err_ff, err_in;
   logic signed [DW-1:0] last_err_ff, last_err_in;
   logic [DW-1:0]        now_ff, now_in, elapsed_ff, elapsed_in, last_time_ff, last_time_in;
   logic                 zero_ff, zero_in, sat_ff, sat_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic signed [TW-1:0] p_ff, p_in, i_ff, i_in, d_ff, d_in;
   logic [IW-1:0]        hi_ff, hi_in;
   logic signed [IW-1:0] integ_ff, integ_in;

   logic [DW-1:0]        mul_a;
   logic [DW:0]          mul_b;
   logic                 div_start, div_busy, div_done;
   logic [epp_pkg::DIV_W-1:0] div_dividend, div_quot;
   logic [DW-1:0]        div_divisor;

   logic signed [DW:0]   diff;
   logic [DW:0]          diff_mag;
   logic [IW-1:0]        integ_mag;
   logic [DW:0]          pm_pos;
   logic signed [TW+1:0] err_wide, drive_sum;
   logic [IW:0]          inc_mag;
   logic                 inc_cap;
   logic signed [IW+2:0] integ_sum;
   logic [TW+1:0]        i_r, i_cap;
   logic [TW-1:0]        term_mag;

   assign diff      = (DW+1)'(err_ff) - (DW+1)'(last_err_ff);
   assign diff_mag  = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
   assign integ_mag = integ_ff[IW-1] ? IW'(-integ_ff) : IW'(integ_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         epp_pkg::OP_MUL_POS: begin
            mul_a = mag32(cnt_ff);
            mul_b = (DW+1)'(epp_pkg::DEG_PER_REV);
         end
         epp_pkg::OP_MUL_P: begin
            mul_a = mag32(cfg.gain_p);
            mul_b = (DW+1)'(mag32(err_ff));
         end
         epp_pkg::OP_MUL_INC: begin
            mul_a = mag32(err_ff);
            mul_b = (DW+1)'(elapsed_ff);
         end
         epp_pkg::OP_MUL_IHI: begin
            mul_a = mag32(cfg.gain_i);
            mul_b = (DW+1)'(integ_mag[IW-1:DW]);
         end
         epp_pkg::OP_MUL_ILO: begin
            mul_a = mag32(cfg.gain_i);
            mul_b = (DW+1)'(integ_mag[DW-1:0]);
         end
         epp_pkg::OP_MUL_D: begin
            mul_a = mag32(cfg.gain_d);
            mul_b = diff_mag;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = prod_ff[epp_pkg::DIV_W-1:0];
      div_divisor  = elapsed_ff;
      if (cmd.op == epp_pkg::OP_DIV_POS) begin
         div_start    = 1'b1;
         div_dividend = epp_pkg::DIV_W'(prod_ff[39:0]) << FRAC_BITS;
         div_divisor  = (cfg.cpr == '0) ? DW'(1) : DW'(cfg.cpr);
      end else if (cmd.op == epp_pkg::OP_DIV_D) begin
         div_start = 1'b1;
      end
   end

   epp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .busy     (div_busy),
      .done     (div_done)
   );

   // arithmetic for each step
   always_comb begin
      pm_pos    = (div_quot[epp_pkg::DIV_W-1:DW] != '0) ? {1'b1, {DW{1'b0}}}
                                                        : {1'b0, div_quot[DW-1:0]};
      err_wide  = (TW+2)'(cfg.setpoint) - (TW+2)'(pos_ff);
      inc_cap   = (prod_ff[TW-1:0] > (TW'(1) << IW));
      inc_mag   = inc_cap ? {1'b1, {IW{1'b0}}} : prod_ff[IW:0];
      integ_sum = (IW+3)'(integ_ff)
                + (err_ff[DW-1] ? -(IW+3)'(inc_mag) : (IW+3)'(inc_mag));
      i_r       = ((TW+2)'(hi_ff) << (DW - FRAC_BITS))
                + (TW+2)'(prod_ff[TW-1:0] >> FRAC_BITS);
      if ((TW+2)'(hi_ff) >= ((TW+2)'(1) << (30 + FRAC_BITS)) || i_r > ((TW+2)'(1) << 62))
         i_cap = (TW+2)'(1) << 62;
      else
         i_cap = i_r;
      term_mag  = div_quot >> FRAC_BITS;
   end

   always_comb begin
      cnt_in       = cnt_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      zero_in      = zero_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      sat_in       = sat_ff;
      hi_in        = hi_ff;
      integ_in     = integ_ff;
      last_err_in  = last_err_ff;
      last_time_in = last_time_ff;
      case (cmd.op)
         epp_pkg::OP_LOAD: begin
            cnt_in     = req_count;
            now_in     = req_time;
            elapsed_in = req_time - last_time_ff;
            zero_in    = (req_time == last_time_ff);
         end
         epp_pkg::OP_POS: begin
            if (!cnt_ff[DW-1])
               pos_in = pm_pos[DW:DW-1] != 2'b00 ? 32'sh7FFF_FFFF : DW'(pm_pos);
            else if (pm_pos > (DW+1)'(33'h0_8000_0000))
               pos_in = 32'sh8000_0000;
            else
               pos_in = DW'(-pm_pos);
         end
         epp_pkg::OP_ERR: begin
            err_in = sat32(err_wide);
         end
         epp_pkg::OP_P_TERM: begin
            p_in   = (cfg.gain_p[DW-1] ^ err_ff[DW-1]) ? -TW'(prod_ff[TW-1:0] >> FRAC_BITS)
                                                     : TW'(prod_ff[TW-1:0] >> FRAC_BITS);
            i_in   = '0;
            d_in   = '0;
            sat_in = 1'b0;
         end
         epp_pkg::OP_INTEG: begin
            if (inc_cap)
               sat_in = 1'b1;
            if (integ_sum > (IW+3)'(signed'({1'b0, {(IW-1){1'b1}}}))) begin
               integ_in = {1'b0, {(IW-1){1'b1}}};
               sat_in   = 1'b1;
            end else if (integ_sum < (IW+3)'(signed'({1'b1, {(IW-1){1'b0}}}))) begin
               integ_in = {1'b1, {(IW-1){1'b0}}};
               sat_in   = 1'b1;
            end else begin
               integ_in = IW'(integ_sum);
            end
         end
         epp_pkg::OP_HI: begin
            hi_in = prod_ff[IW-1:0];
         end
         epp_pkg::OP_I_TERM: begin
            i_in = (cfg.gain_i[DW-1] ^ integ_ff[IW-1]) ? -TW'(i_cap) : TW'(i_cap);
         end
         epp_pkg::OP_D_TERM: begin
            d_in = (cfg.gain_d[DW-1] ^ diff[DW]) ? -term_mag : term_mag;
         end
         epp_pkg::OP_FINISH: begin
            last_err_in  = err_ff;
            last_time_in = now_ff;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff  <= '0;
         last_time_ff <= '0;
         integ_ff     <= '0;
      end else begin
         last_err_ff  <= last_err_in;
         last_time_ff <= last_time_in;
         integ_ff     <= integ_in;
      end
      cnt_ff     <= cnt_in;
      now_ff     <= now_in;
      elapsed_ff <= elapsed_in;
      zero_ff    <= zero_in;
      pos_ff     <= pos_in;
      err_ff     <= err_in;
      p_ff       <= p_in;
      i_ff       <= i_in;
      d_ff       <= d_in;
      sat_ff     <= sat_in;
      hi_ff      <= hi_in;
      prod_ff    <= prod_in;
   end

   assign drive_sum       = (TW+2)'(p_ff) + (TW+2)'(i_ff) + (TW+2)'(d_ff);
   assign drive           = sat32(drive_sum);
   assign drive_saturated = sat_ff | (drive_sum != (TW+2)'(drive));
   assign position_deg    = pos_ff;
   assign zero_interval   = zero_ff;

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;
   assign status.zero     = zero_ff;
endmodule

FILE: hdl/epp_controller.sv
// Step sequencer for one sample.
module epp_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      slot_free,
   input  epp_pkg::epp_status_type   status,
   output logic                      req_ready,
   output epp_pkg::epp_cmd_type      cmd
);
   epp_pkg::epp_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         epp_pkg::ST_IDLE:      if (req_valid) state_in = epp_pkg::ST_MPOS;
         epp_pkg::ST_MPOS:      state_in = epp_pkg::ST_DPOS_GO;
         epp_pkg::ST_DPOS_GO:   state_in = epp_pkg::ST_DPOS_WAIT;
         epp_pkg::ST_DPOS_WAIT: if (status.div_done) state_in = epp_pkg::ST_POS;
         epp_pkg::ST_POS:       state_in = epp_pkg::ST_ERR;
         epp_pkg::ST_ERR:       state_in = epp_pkg::ST_MP;
         epp_pkg::ST_MP:        state_in = epp_pkg::ST_PT;
         epp_pkg::ST_PT:        state_in = status.zero ? epp_pkg::ST_FIN : epp_pkg::ST_MINC;
         epp_pkg::ST_MINC:      state_in = epp_pkg::ST_INTEG;
         epp_pkg::ST_INTEG:     state_in = epp_pkg::ST_MIHI;
         epp_pkg::ST_MIHI:      state_in = epp_pkg::ST_IHI;
         epp_pkg::ST_IHI:       state_in = epp_pkg::ST_MILO;
         epp_pkg::ST_MILO:      state_in = epp_pkg::ST_ITERM;
         epp_pkg::ST_ITERM:     state_in = epp_pkg::ST_MD;
         epp_pkg::ST_MD:        state_in = epp_pkg::ST_DD_GO;
         epp_pkg::ST_DD_GO:     state_in = epp_pkg::ST_DD_WAIT;
         epp_pkg::ST_DD_WAIT:   if (status.div_done) state_in = epp_pkg::ST_DT;
         epp_pkg::ST_DT:        state_in = epp_pkg::ST_FIN;
         epp_pkg::ST_FIN:       if (slot_free) state_in = epp_pkg::ST_IDLE;
         default:               state_in = epp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = epp_pkg::OP_NONE;
      cmd.out_load = 1'b0;
      case (state_ff)
         epp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = epp_pkg::OP_LOAD;
         end
         epp_pkg::ST_MPOS:    cmd.op = epp_pkg::OP_MUL_POS;
         epp_pkg::ST_DPOS_GO: cmd.op = epp_pkg::OP_DIV_POS;
         epp_pkg::ST_POS:     cmd.op = epp_pkg::OP_POS;
         epp_pkg::ST_ERR:     cmd.op = epp_pkg::OP_ERR;
         epp_pkg::ST_MP:      cmd.op = epp_pkg::OP_MUL_P;
         epp_pkg::ST_PT:      cmd.op = epp_pkg::OP_P_TERM;
         epp_pkg::ST_MINC:    cmd.op = epp_pkg::OP_MUL_INC;
         epp_pkg::ST_INTEG:   cmd.op = epp_pkg::OP_INTEG;
         epp_pkg::ST_MIHI:    cmd.op = epp_pkg::OP_MUL_IHI;
         epp_pkg::ST_IHI:     cmd.op = epp_pkg::OP_HI;
         epp_pkg::ST_MILO:    cmd.op = epp_pkg::OP_MUL_ILO;
         epp_pkg::ST_ITERM:   cmd.op = epp_pkg::OP_I_TERM;
         epp_pkg::ST_MD:      cmd.op = epp_pkg::OP_MUL_D;
         epp_pkg::ST_DD_GO:   cmd.op = epp_pkg::OP_DIV_D;
         epp_pkg::ST_DT:      cmd.op = epp_pkg::OP_D_TERM;
         epp_pkg::ST_FIN: begin
            if (slot_free) begin
               cmd.op       = epp_pkg::OP_FINISH;
               cmd.out_load = 1'b1;
            end
         end
         default: cmd.op = epp_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= epp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: hdl/encoder_position_pid_unit.sv
// Samples are taken one at a time; the pace is set by the two 64-bit divisions (position
//   scaling, derivative) on the shared divider at two bits a cycle; zero elapsed skips the second.
// Reset (synchronous, active high): setpoint 180, gains 5 / 0.1 / 0.06, 88064 counts per
//   rev; last time, last error and error integral clear; no rsp pending.
`include "encoder_position_pid_unit_defines.svh"

module encoder_position_pid_unit #(
   parameter int FRAC_BITS = epp_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   epp_csr_if.sink    csr_bus,
   epp_req_if.sink    req_bus,
   epp_rsp_if.source  rsp_bus
);
   // Config registers, written whenever a csr transfer happens.
   epp_pkg::epp_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            epp_pkg::REG_SETPOINT: cfg_in.setpoint = csr_bus.data;
            epp_pkg::REG_GAIN_P:   cfg_in.gain_p   = csr_bus.data;
            epp_pkg::REG_GAIN_I:   cfg_in.gain_i   = csr_bus.data;
            epp_pkg::REG_GAIN_D:   cfg_in.gain_d   = csr_bus.data;
            epp_pkg::REG_CPR:      cfg_in.cpr      = csr_bus.data[epp_pkg::CPR_W-1:0];
            default:               cfg_in = cfg_ff;  // unmapped index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint <= epp_pkg::SETPOINT_RST;
         cfg_ff.gain_p   <= epp_pkg::GAIN_P_RST;
         cfg_ff.gain_i   <= epp_pkg::GAIN_I_RST;
         cfg_ff.gain_d   <= epp_pkg::GAIN_D_RST;
         cfg_ff.cpr      <= epp_pkg::CPR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_bus.ready = 1'b1;

   // Controller / datapath.
   epp_pkg::epp_cmd_type    dp_cmd;
   epp_pkg::epp_status_type dp_status;
   logic                              slot_free;
   logic signed [epp_pkg::DATA_W-1:0] dp_drive, dp_pos;
   logic                              dp_sat, dp_zero;

   epp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .slot_free (slot_free),
      .status    (dp_status),
      .req_ready (req_bus.ready),
      .cmd       (dp_cmd)
   );

   epp_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_count       (req_bus.encoder_count),
      .req_time        (req_bus.time_us),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .drive           (dp_drive),
      .position_deg    (dp_pos),
      .drive_saturated (dp_sat),
      .zero_interval   (dp_zero)
   );

   // Output register: a finished result waits here while the next sample is taken.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [epp_pkg::DATA_W-1:0] drive_ff, pos_ff;
   logic                              sat_ff, zero_ff;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (dp_cmd.out_load) begin
         drive_ff <= dp_drive;
         pos_ff   <= dp_pos;
         sat_ff   <= dp_sat;
         zero_ff  <= dp_zero;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.drive           = drive_ff;
   assign rsp_bus.position_deg    = pos_ff;
   assign rsp_bus.drive_saturated = sat_ff;
   assign rsp_bus.zero_interval   = zero_ff;

   // Never overwrite a result that has not been taken.
   `EPP_ASSERT_SAME(a_out_slot, dp_cmd.out_load, (!rsp_valid_ff || rsp_bus.ready), "result overwritten")
   // The shared divider is only started when idle.
   `EPP_ASSERT_SAME(a_div_idle, (dp_cmd.op == epp_pkg::OP_DIV_POS || dp_cmd.op == epp_pkg::OP_DIV_D), !dp_status.div_busy, "divider restarted while busy")
   // One sample in flight: no second transfer right after one.
   `EPP_ASSERT_NEXT(a_one_inflight, (req_bus.valid && req_bus.ready), !req_bus.ready, "second sample taken while busy")
endmodule

FILE: verif/encoder_position_pid_unit_tb.sv
// Encoder position PID unit: directed corner samples, register sweeps, random
// sample streams and back-pressure, checked against an in-bench fixed-point model.
module encoder_position_pid_unit_tb;

   localparam int HALF_PERIOD = 10;
   localparam int SETTLE_CYCLES = 120;    // covers a full sample from req transfer to rsp valid
   localparam longint I32_HI = 64'sd2147483647;
   localparam longint I32_LO = -64'sd2147483648;
   localparam longint I48_HI = 64'sd140737488355327;
   localparam longint I48_LO = -64'sd140737488355328;
   localparam longint unsigned TERM_CAP = 64'h4000_0000_0000_0000;
   localparam int FB = epp_pkg::FRAC_BITS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   epp_csr_if csr_bus ();
   epp_req_if req_bus ();
   epp_rsp_if rsp_bus ();

   encoder_position_pid_unit dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // One expected drive result.
   typedef struct {
      logic signed [epp_pkg::DATA_W-1:0] drive;
      logic signed [epp_pkg::DATA_W-1:0] position;
      logic                              saturated;
      logic                              zero_dt;
   } drive_result_type;

   drive_result_type pending_drives[$];

   // Model copy of registers and PID state.
   longint          setpoint_m, kp_m, ki_m, kd_m;
   longint unsigned cpr_m;
   logic [31:0]     prev_time_m;
   longint          prev_err_m, err_sum_m;

   int  mismatches = 0;
   int  samples_sent = 0;
   int  drives_checked = 0;
   bit  idle_on = 1'b1;
   int  hold_left = 0;      // long receiver hold-off, set by the pressure test
   int  rsp_gap = 0;
   logic [31:0] t_cursor = '0;

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint with_sign(longint unsigned m, bit neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi, inout bit hit);
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // Gain times integral with the product capped at 2^62 before the sign.
   function automatic longint gain_times_sum(longint g, longint s);
      longint unsigned mg, ms, hi, lo, r;
      mg = mag(g);
      ms = mag(s);
      hi = mg * (ms >> 32);
      lo = mg * (ms & 64'hFFFF_FFFF);
      if (hi >= (TERM_CAP >> (32 - FB))) r = TERM_CAP;
      else begin
         r = (hi << (32 - FB)) + (lo >> FB);
         if (r > TERM_CAP) r = TERM_CAP;
      end
      return with_sign(r, (g < 0) != (s < 0));
   endfunction

   function automatic longint count_to_deg(logic signed [31:0] count);
      longint unsigned cpr, m, q, r, pm;
      bit dummy;
      dummy = 1'b0;
      cpr = (cpr_m == 0) ? 1 : cpr_m;
      m = mag(longint'(count)) * 360;
      q = m / cpr;
      r = m % cpr;
      if (q >= (64'h1_0000_0000 >> FB)) pm = 64'h1_0000_0000;
      else pm = (q << FB) + ((r << FB) / cpr);
      return clip(with_sign(pm, count < 0), I32_LO, I32_HI, dummy);
   endfunction

   // Advance the model by one sample and return the drive it yields.
   function automatic drive_result_type step_pid(logic signed [31:0] count, logic [31:0] now);
      drive_result_type res;
      longint pos, err, p_term, i_term, d_term, total, diff;
      longint unsigned pm, dm;
      logic [31:0] dt;
      bit sat, dummy;
      sat = 1'b0;
      dummy = 1'b0;
      pos = count_to_deg(count);
      err = clip(setpoint_m - pos, I32_LO, I32_HI, dummy);
      dt = now - prev_time_m;
      p_term = with_sign((mag(kp_m) * mag(err)) >> FB, (kp_m < 0) != (err < 0));
      i_term = 0;
      d_term = 0;
      if (dt != 0) begin
         pm = mag(err) * longint'(dt);
         if (pm > (64'd1 << 48)) begin
            pm = 64'd1 << 48;
            sat = 1'b1;
         end
         err_sum_m = clip(err_sum_m + with_sign(pm, err < 0), I48_LO, I48_HI, sat);
         i_term = gain_times_sum(ki_m, err_sum_m);
         diff = err - prev_err_m;
         dm = mag(kd_m) * mag(diff);
         dm = (dm / longint'(dt)) >> FB;
         d_term = with_sign(dm, (kd_m < 0) != (diff < 0));
      end
      total = clip(p_term + i_term + d_term, I32_LO, I32_HI, sat);
      prev_err_m = err;
      prev_time_m = now;
      res.drive = total[31:0];
      res.position = pos[31:0];
      res.saturated = sat;
      res.zero_dt = (dt == 0);
      return res;
   endfunction

   // Receiver: ready driven at falling edge; per-result stall draw, plus long hold.
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else rsp_bus.ready <= 1'b1;
   end

   // Result checker: every rsp transfer against the oldest expected drive.
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_gap = idle_on ? $urandom_range(0, 11) : 0;
         if (pending_drives.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp: drive %0d pos %0d", rsp_bus.drive,
                        rsp_bus.position_deg);
         end else begin
            want = pending_drives.pop_front();
            drives_checked++;
            if (rsp_bus.drive !== want.drive || rsp_bus.position_deg !== want.position ||
                rsp_bus.drive_saturated !== want.saturated ||
                rsp_bus.zero_interval !== want.zero_dt) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp %0d: exp drive %0d pos %0d sat %b zero %b, got %0d %0d %b %b",
                           drives_checked, want.drive, want.position, want.saturated,
                           want.zero_dt, rsp_bus.drive, rsp_bus.position_deg,
                           rsp_bus.drive_saturated, rsp_bus.zero_interval);
            end
         end
      end
   end

   // One sample transfer; valid stays up when the next sample follows with no gap.
   task automatic send_sample(logic signed [31:0] count, logic [31:0] now);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.encoder_count <= count;
      req_bus.time_us <= now;
      do @(posedge clock); while (!req_bus.ready);
      pending_drives.push_back(step_pid(count, now));
      samples_sent++;
      t_cursor = now;
   endtask

   // Stop offering and wait until every drive has come back.
   task automatic drain_drives();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
   endtask

   // Register transfer, only while the block is idle.
   task automatic write_reg(epp_pkg::csr_reg_type idx, logic [31:0] value);
      drain_drives();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         epp_pkg::REG_SETPOINT: setpoint_m = longint'(signed'(value));
         epp_pkg::REG_GAIN_P:   kp_m = longint'(signed'(value));
         epp_pkg::REG_GAIN_I:   ki_m = longint'(signed'(value));
         epp_pkg::REG_GAIN_D:   kd_m = longint'(signed'(value));
         epp_pkg::REG_CPR:      cpr_m = longint'(value[epp_pkg::CPR_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] pick_count();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: return signed'($urandom_range(0, 20_000_000)) - 32'sd10_000_000;
         default: return signed'($urandom_range(0, 400_000)) - 32'sd200_000;
      endcase
   endfunction

   // Mostly steady sampling; some repeated stamps, some wild jumps and wraps.
   function automatic logic [31:0] pick_time();
      case ($urandom_range(0, 29))
         0, 1: return t_cursor;
         2: return $urandom;
         3: return t_cursor + $urandom_range(100_000, 5_000_000);
         default: return t_cursor + $urandom_range(1, 2000);
      endcase
   endfunction

   task automatic random_stream(int n);
      repeat (n) send_sample(pick_count(), pick_time());
   endtask

   // Defaults straight out of reset, field extremes, zero elapsed, wrap.
   task automatic test_reset_corners();
      send_sample(32'sd0, 32'd0);
      send_sample(32'sd0, 32'd0);
      send_sample(32'sd22016, 32'd1000);
      send_sample(32'sh7FFF_FFFF, 32'd2000);
      send_sample(32'sh8000_0000, 32'd2000);
      send_sample(-32'sd1, 32'hFFFF_FFFF);
      send_sample(32'sd1, 32'd5);
      send_sample(32'sd88064, 32'h8000_0000);
      send_sample(-32'sd44032, 32'h8000_0001);
      send_sample(32'sh5555_5555, 32'hAAAA_AAAA);
      send_sample(32'shAAAA_AAAA, 32'h5555_5555);
      drain_drives();
   endtask

   // Register extremes: saturating gains, tiny and huge counts per rev.
   task automatic test_register_extremes();
      write_reg(epp_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
      write_reg(epp_pkg::REG_GAIN_I, 32'h8000_0000);
      write_reg(epp_pkg::REG_GAIN_D, 32'h7FFF_FFFF);
      write_reg(epp_pkg::REG_SETPOINT, 32'h7FFF_FFFF);
      write_reg(epp_pkg::REG_CPR, 32'h0000_0001);
      send_sample(32'sh8000_0000, 32'h1234_0000);
      send_sample(32'sh7FFF_FFFF, 32'h1234_0001);
      send_sample(32'sd3, 32'h2234_0001);
      write_reg(epp_pkg::REG_CPR, 32'h0000_0000);   // zero acts as one
      write_reg(epp_pkg::REG_SETPOINT, 32'h8000_0000);
      send_sample(32'sd5, 32'h2234_0100);
      send_sample(-32'sd5, 32'h2234_0100);
      write_reg(epp_pkg::REG_CPR, 32'h00FF_FFFF);
      write_reg(epp_pkg::REG_GAIN_P, 32'h8000_0000);
      write_reg(epp_pkg::REG_GAIN_I, 32'h7FFF_FFFF);
      write_reg(epp_pkg::REG_GAIN_D, 32'h8000_0000);
      send_sample(32'sh7FFF_FFFF, 32'h3000_0000);
      send_sample(32'sh8000_0000, 32'h3000_0001);
      send_sample(32'sd0, 32'hF000_0000);
      drain_drives();
   endtask

   // Several register settings, each followed by a random stream.
   task automatic test_random_settings();
      write_reg(epp_pkg::REG_SETPOINT, 32'd11796480);
      write_reg(epp_pkg::REG_GAIN_P, 32'd327680);
      write_reg(epp_pkg::REG_GAIN_I, 32'd6554);
      write_reg(epp_pkg::REG_GAIN_D, 32'd3932);
      write_reg(epp_pkg::REG_CPR, 32'd88064);
      random_stream(480);
      for (int k = 0; k < 6; k++) begin
         write_reg(epp_pkg::REG_SETPOINT, $urandom);
         write_reg(epp_pkg::REG_GAIN_P,
                   (k % 2) ? $urandom : $urandom_range(0, 2_000_000) - 1_000_000);
         write_reg(epp_pkg::REG_GAIN_I,
                   (k % 2) ? $urandom : $urandom_range(0, 20_000) - 10_000);
         write_reg(epp_pkg::REG_GAIN_D, $urandom);
         write_reg(epp_pkg::REG_CPR, (k == 5) ? $urandom : $urandom_range(1, 200_000));
         idle_on = (k != 2);
         random_stream(140);
      end
      idle_on = 1'b1;
      drain_drives();
   endtask

   // Receiver holds off long while samples keep coming; then sender waits it out.
   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_left = 600;
      random_stream(20);
      drain_drives();
      idle_on = 1'b1;
      random_stream(40);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.encoder_count = '0;
      req_bus.time_us = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = epp_pkg::REG_SETPOINT;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      setpoint_m = longint'(epp_pkg::SETPOINT_RST);
      kp_m = longint'(epp_pkg::GAIN_P_RST);
      ki_m = longint'(epp_pkg::GAIN_I_RST);
      kd_m = longint'(epp_pkg::GAIN_D_RST);
      cpr_m = longint'(epp_pkg::CPR_RST);
      prev_time_m = '0;
      prev_err_m = 0;
      err_sum_m = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_corners();
      test_register_extremes();
      test_random_settings();
      test_backpressure();

      drain_drives();
      repeat (SETTLE_CYCLES) @(posedge clock);
      foreach (pending_drives[i]) mismatches++;
      $display("covered %0d samples and %0d checked drives over reset, extreme and random",
               samples_sent, drives_checked);
      $display("register settings, with receiver hold-off and drain pauses");
      if (mismatches == 0) begin
         $display("PASS encoder_position_pid_unit");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL encoder_position_pid_unit");
      end
      $finish;
   end

   // Hang guard, far above the slowest legal run.
   initial begin
      #80_000_000;
      $display("timeout");
      $display("FAIL encoder_position_pid_unit");
      $finish;
   end

endmodule
